// ----- rtl/ptg_pkg.sv -----
// ptg_pkg: shared widths, constants, state enum and control/status structs for the
// prime table generator. No dependencies.
package ptg_pkg;

    localparam int VAL_W = 13;
    localparam int IDX_W = 10;
    localparam int CNT_W = $clog2(VAL_W + 1);
    localparam int TABLE_DEPTH_DEF = 1024;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_val VAL_MAX   = t_val'(8191);
    localparam t_idx STOP_RST  = t_idx'(999);
    localparam t_val CAND_SEED = t_val'(5);
    localparam t_val SEED_P0   = t_val'(2);
    localparam t_val SEED_P1   = t_val'(3);
    localparam t_idx LAST_SEED = t_idx'(1);
    localparam t_val CAND_STEP = t_val'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        t_val dividend;
        t_val divisor;
    } t_rem_ctl;

    typedef struct packed {
        logic done;   // one-cycle pulse, remainder ready
        logic hit;    // divisor nonzero and divides the dividend
    } t_rem_sts;

endpackage

// ----- rtl/ptg_if.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on ptg_pkg.
interface ptg_in_if;
    import ptg_pkg::*;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ptg_out_if;
    import ptg_pkg::*;
    logic valid;
    logic ready;
    t_val prime_value;
    logic exhausted;

    modport source (output valid, output prime_value, output exhausted, input ready);
    modport sink   (input valid, input prime_value, input exhausted, output ready);
endinterface

// ----- rtl/prime_table_generator.sv -----
// prime_table_generator: top level, sequencer, prime table and result register.
// Depends on ptg_pkg, ptg_if, ptg_ram and ptg_rem.
//
//  channel  | dir | beat payload               | notes
//  ---------+-----+----------------------------+------------------------------
//  i_in     | in  | restart                    | ready only while idle
//  o_out    | out | prime_value, exhausted     | one beat per request
//  i_cfg_*  | in  | stop_index (i_cfg_wdata)   | write at any edge with we high
//
// Each stored prime tried against the candidate costs a table read, a divisor
// load, 13 remainder steps in the shared bit-serial unit, and the check.
// A composite candidate stops at its first divisor, a prime runs the whole table,
// and the result register is then loaded. Restart and exhausted requests go
// straight to the result state. Seeds 2 and 3 are constants, so reset needs no
// table pass. A result waits in the output register under back-pressure; the next
// request is taken once the sequencer has handed its result over.
module prime_table_generator #(
    parameter int TABLE_DEPTH = ptg_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptg_in_if.sink            i_in,
    ptg_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  ptg_pkg::t_idx     i_cfg_wdata
);
    import ptg_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int unsigned LAST_ENTRY = TABLE_DEPTH - 1;

    t_state r_state, n_state;
    t_idx   r_stop;
    t_idx   r_last, n_last;
    t_val   r_cand, n_cand;
    logic   r_done, n_done;
    t_idx   r_idx, n_idx;
    t_val   r_c, n_c;
    t_val   r_res_prime, n_res_prime;
    logic   r_res_exh, n_res_exh;
    logic   r_ov;
    t_val   r_op;
    logic   r_oe;

    t_idx     s_eff_stop;
    t_idx     s_next_last;
    logic [VAL_W:0] s_c_step;
    logic     s_c_ovf;
    logic     s_in_beat;
    logic     s_load_out;
    logic     s_we;
    t_val     s_rdata;
    t_val     s_divisor;
    t_rem_ctl s_rem_ctl;
    t_rem_sts s_rem_sts;

    assign s_eff_stop  = (32'(r_stop) > LAST_ENTRY) ? t_idx'(LAST_ENTRY) : r_stop;
    assign s_next_last = r_last + t_idx'(1);
    assign s_c_step    = {1'b0, r_c} + {1'b0, CAND_STEP};
    assign s_c_ovf     = s_c_step > {1'b0, VAL_MAX};
    assign s_in_beat   = i_in.valid && i_in.ready;
    assign s_load_out  = (r_state == S_RESULT) && (!r_ov || o_out.ready);

    always_comb begin
        case (r_idx)
            t_idx'(0): s_divisor = SEED_P0;
            t_idx'(1): s_divisor = SEED_P1;
            default:   s_divisor = s_rdata;
        endcase
    end

    ptg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (AW'(s_next_last)),
        .i_wdata (r_c),
        .i_raddr (AW'(r_idx)),
        .o_rdata (s_rdata)
    );

    assign s_rem_ctl.start    = (r_state == S_START);
    assign s_rem_ctl.dividend = r_c;
    assign s_rem_ctl.divisor  = s_divisor;

    ptg_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_rem_ctl),
        .o_sts   (s_rem_sts)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_in_beat) begin
                    if (i_in.restart || r_done || (r_last >= s_eff_stop)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (s_rem_sts.done) begin
                    if (s_rem_sts.hit) begin
                        n_state = s_c_ovf ? S_RESULT : S_READ;
                    end else if (r_idx == r_last) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_RESULT: begin
                if (s_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_last      = r_last;
        n_cand      = r_cand;
        n_done      = r_done;
        n_idx       = r_idx;
        n_c         = r_c;
        n_res_prime = r_res_prime;
        n_res_exh   = r_res_exh;
        s_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_in_beat) begin
                    n_res_prime = '0;
                    n_res_exh   = 1'b0;
                    n_idx       = '0;
                    n_c         = r_cand;
                    if (i_in.restart) begin
                        n_last = LAST_SEED;
                        n_cand = CAND_SEED;
                        n_done = 1'b0;
                    end else if (r_done || (r_last >= s_eff_stop)) begin
                        n_done    = 1'b1;
                        n_res_exh = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (s_rem_sts.done) begin
                    if (s_rem_sts.hit) begin
                        if (s_c_ovf) begin
                            n_done    = 1'b1;
                            n_res_exh = 1'b1;
                        end else begin
                            n_c   = s_c_step[VAL_W-1:0];
                            n_idx = '0;
                        end
                    end else if (r_idx == r_last) begin
                        // no stored prime divides: append and report
                        s_we        = 1'b1;
                        n_last      = s_next_last;
                        n_cand      = s_c_step[VAL_W-1:0];
                        n_done      = r_done || s_c_ovf || (s_next_last >= s_eff_stop);
                        n_res_prime = r_c;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stop  <= STOP_RST;
            r_last  <= LAST_SEED;
            r_cand  <= CAND_SEED;
            r_done  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_cand  <= n_cand;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_stop <= i_cfg_wdata;
            end
            if (s_load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_c         <= n_c;
        r_res_prime <= n_res_prime;
        r_res_exh   <= n_res_exh;
        if (s_load_out) begin
            r_op <= r_res_prime;
            r_oe <= r_res_exh;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.prime_value = r_op;
    assign o_out.exhausted   = r_oe;
endmodule

// ----- rtl/ptg_ram.sv -----
// ptg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ptg_rem.sv -----
// ptg_rem: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on ptg_pkg.
module ptg_rem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptg_pkg::t_rem_ctl   i_ctl,
    output ptg_pkg::t_rem_sts   o_sts
);
    import ptg_pkg::*;

    t_val r_rem, n_rem;
    t_val r_dvd;
    t_val r_div;
    t_cnt r_cnt;
    logic r_busy;
    logic r_fin;

    logic [VAL_W:0] s_trial;
    logic [VAL_W:0] s_sub;

    always_comb begin
        s_trial = {r_rem, r_dvd[VAL_W-1]};
        s_sub   = s_trial;
        if (s_trial >= {1'b0, r_div}) begin
            s_sub = s_trial - {1'b0, r_div};
        end
        n_rem = s_sub[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_cnt'(VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - t_cnt'(1);
                if (r_cnt == t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dvd <= i_ctl.dividend;
            r_div <= i_ctl.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
        end
    end

    assign o_sts.done = r_fin;
    assign o_sts.hit  = r_fin && (r_rem == '0) && (r_div != '0);
endmodule

// ----- tb/tb_prime_table_generator.sv -----
// Self-checking testbench for prime_table_generator: drives restart/next-prime
// requests and stop_index writes, and checks every result beat against a predictor.
// Depends on ptg_pkg, ptg_if and the prime_table_generator RTL.
`timescale 1ns / 100ps

import ptg_pkg::*;

typedef struct packed {
    t_val prime_value;
    logic exhausted;
} t_prime_beat;

class prime_scoreboard;
    t_val        primes [TABLE_DEPTH_DEF];
    t_idx        top_idx;
    int unsigned next_cand;
    bit          halted;
    t_idx        stop_idx;
    t_prime_beat expected_q [$];
    int          fails;
    int          n_primes;
    int          n_exhausted;
    int          n_restarts;
    int          n_writes;

    function new();
        stop_idx = STOP_RST;
        reseed();
    endfunction

    function void reseed();
        primes[0] = SEED_P0;
        primes[1] = SEED_P1;
        top_idx   = LAST_SEED;
        next_cand = CAND_SEED;
        halted    = 1'b0;
    endfunction

    function void set_stop(t_idx v);
        stop_idx = v;
        n_writes++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Work out the result of one accepted request beat and queue it.
    function void note_request(logic restart);
        t_prime_beat beat;
        int unsigned limit;
        int unsigned c;
        bit          hit;
        bit          overflow;
        beat  = '0;
        limit = (stop_idx > TABLE_DEPTH_DEF - 1) ? TABLE_DEPTH_DEF - 1 : stop_idx;
        if (restart) begin
            reseed();
            n_restarts++;
        end else if (halted || top_idx >= limit) begin
            halted = 1'b1;
            beat.exhausted = 1'b1;
        end else begin
            c = next_cand;
            overflow = 1'b0;
            forever begin
                // every stored prime is tried, not only those up to the root
                hit = 1'b0;
                for (int i = 0; i <= top_idx; i++) begin
                    if (primes[i] != 0 && (c % primes[i]) == 0)
                        hit = 1'b1;
                end
                if (!hit)
                    break;
                if (c + CAND_STEP > VAL_MAX) begin
                    overflow = 1'b1;
                    break;
                end
                c += CAND_STEP;
            end
            if (overflow) begin
                halted = 1'b1;
                beat.exhausted = 1'b1;
            end else begin
                top_idx = top_idx + 1'b1;
                primes[top_idx] = t_val'(c);
                if (c + CAND_STEP > VAL_MAX) begin
                    halted = 1'b1;
                    next_cand = (c + CAND_STEP) & VAL_MAX;
                end else begin
                    next_cand = c + CAND_STEP;
                end
                if (top_idx >= limit)
                    halted = 1'b1;
                beat.prime_value = t_val'(c);
            end
        end
        if (beat.exhausted)
            n_exhausted++;
        else if (!restart)
            n_primes++;
        expected_q.push_back(beat);
    endfunction

    function void check(t_val pv, logic ex);
        t_prime_beat want;
        if (expected_q.size() == 0) begin
            $display("%0t unexpected result beat: prime_value %0d exhausted %0b",
                     $time, pv, ex);
            fails++;
            return;
        end
        want = expected_q.pop_front();
        if (pv !== want.prime_value) begin
            $display("%0t prime_value mismatch: expected %0d, actual %0d",
                     $time, want.prime_value, pv);
            fails++;
        end
        if (ex !== want.exhausted) begin
            $display("%0t exhausted mismatch: expected %0b, actual %0b",
                     $time, want.exhausted, ex);
            fails++;
        end
    endfunction
endclass

module tb_prime_table_generator;

    localparam int RANDOM_ITEMS = 118;
    localparam int TABLE_CAP    = 48;       // keeps trial division cheap
    localparam int CYCLE_LIMIT  = 4000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_idx i_cfg_wdata;

    int src_idle_pct;
    int dst_idle_pct;
    int cycle_count = 0;

    prime_scoreboard sb;

    ptg_in_if  req_if ();
    ptg_out_if res_if ();

    prime_table_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if.sink),
        .o_out       (res_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_prime_table_generator NOT OK");
            $finish;
        end
    end

    // result side: sample the beat, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check(res_if.prime_value, res_if.exhausted);
        res_if.ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Called at a clock edge; returns at the edge that accepts the beat,
    // with valid still high so the next beat can follow without a gap.
    task automatic send_item(input logic restart);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid   <= 1'b0;
            req_if.restart <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sb.note_request(restart);
    endtask

    task automatic drain(input int settle);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_stop(input t_idx v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_stop(v);
    endtask

    initial begin
        int   rand_items;
        int   burst_len;
        t_idx stop_val;
        logic restart;

        sb = new();
        src_idle_pct   = 37;
        dst_idle_pct   = 49;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first primes under the reset stop_index, restart mid-run
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);

        // lowest stop that yields a prime: already at it, then one prime after restart
        drain(4);
        write_stop(t_idx'(2));
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);

        // stop at 0 and 1 means no prime at all
        drain(4);
        write_stop('0);
        send_item(1'b1);
        send_item(1'b0);
        drain(4);
        write_stop(t_idx'(1));
        send_item(1'b1);
        send_item(1'b0);

        // widest stop, then lowered below the current index
        drain(4);
        write_stop('1);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        drain(4);
        write_stop(t_idx'(3));
        send_item(1'b0);
        send_item(1'b1);

        // random bursts: mostly a restart followed by runs of requests
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(2) == 0) begin
                drain(4);
                case ($urandom_range(7))
                    0: stop_val = '1;
                    1: stop_val = '0;
                    2: stop_val = t_idx'(1);
                    3: stop_val = t_idx'(2);
                    4: stop_val = t_idx'($urandom_range(1023));
                    default: stop_val = t_idx'($urandom_range(40, 3));
                endcase
                write_stop(stop_val);
            end
            burst_len = $urandom_range(30, 1);
            for (int k = 0; k <= burst_len && rand_items < RANDOM_ITEMS; k++) begin
                case (rand_items * 3 / RANDOM_ITEMS)
                    0: begin
                        src_idle_pct = 37;
                        dst_idle_pct = 49;
                    end
                    1: begin
                        src_idle_pct = 49;
                        dst_idle_pct = 37;
                    end
                    default: begin
                        src_idle_pct = 0;
                        dst_idle_pct = 0;
                    end
                endcase
                restart = (k == 0 && $urandom_range(1) == 0) ||
                          ($urandom_range(19) == 0) || (sb.top_idx >= TABLE_CAP);
                send_item(restart);
                rand_items++;
            end
        end

        drain(64);
        $display("requests: %0d primes, %0d exhausted, %0d restarts",
                 sb.n_primes, sb.n_exhausted, sb.n_restarts);
        $display("stop_index writes: %0d, cycles: %0d", sb.n_writes, cycle_count);
        if (sb.fails == 0) begin
            $display("tb_prime_table_generator OK");
        end else begin
            $display("tb_prime_table_generator NOT OK");
        end
        $finish;
    end

endmodule
